// File: sv/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants for the keyed slot table
// Holds the table size, the action and status codes, the controller states,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 5;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the request and restart the scan
        logic step;    // examine the current slot and advance
        logic commit;  // apply the update and load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic skip;      // request needs no scan (clear or key zero)
        logic last;      // scan sits on the final slot
        logic out_free;  // result register can take a new transaction
    } t_sts;

endpackage

// File: sv/kst_ctrl.sv
// ----------------------------------------------------------------------------
// kst_ctrl: sequencer for the keyed slot table
// Accepts one request, walks the slot scan unless the request needs none,
// then commits once the result register has room.
// ----------------------------------------------------------------------------
module kst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kst_pkg::t_sts i_sts,
    output kst_pkg::t_cmd o_cmd
);

    kst_pkg::t_state r_state;
    kst_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            kst_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kst_pkg::S_SCAN;
                end
            end
            kst_pkg::S_SCAN: begin
                if (i_sts.skip) begin
                    n_state = kst_pkg::S_COMMIT;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last) begin
                        n_state = kst_pkg::S_COMMIT;
                    end
                end
            end
            kst_pkg::S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = kst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/kst_dpath.sv
// ----------------------------------------------------------------------------
// kst_dpath: slot storage, scan unit and result register
// Scans one slot per cycle for a key match and the lowest free slot, then
// applies the request and registers the result.
// ----------------------------------------------------------------------------
module kst_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kst_pkg::t_cmd                i_cmd,
    output kst_pkg::t_sts                o_sts,
    input  logic [1:0]                   i_action,
    input  logic [kst_pkg::KEY_W-1:0]    i_serial,
    input  logic [kst_pkg::VAL_W-1:0]    i_counter_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic [kst_pkg::VAL_W-1:0]    o_found_counter,
    output logic [kst_pkg::CNT_W-1:0]    o_entry_count
);

    // slot storage; keys and values are only seen through their valid bit
    logic [kst_pkg::SLOT_COUNT-1:0] r_valid;
    logic [kst_pkg::KEY_W-1:0]      r_key_mem [kst_pkg::SLOT_COUNT];
    logic [kst_pkg::VAL_W-1:0]      r_val_mem [kst_pkg::SLOT_COUNT];
    logic [kst_pkg::CNT_W-1:0]      r_count;

    // captured request
    kst_pkg::t_action               r_action;
    logic [kst_pkg::KEY_W-1:0]      r_key;
    logic [kst_pkg::VAL_W-1:0]      r_value;

    // scan state
    logic [kst_pkg::IDX_W-1:0]      r_idx;
    logic                           r_hit;
    logic [kst_pkg::IDX_W-1:0]      r_hit_idx;
    logic [kst_pkg::VAL_W-1:0]      r_hit_val;
    logic                           r_free;
    logic [kst_pkg::IDX_W-1:0]      r_free_idx;

    // registered slot read, fetched in the cycle before the scan examines it
    logic [kst_pkg::IDX_W-1:0]      rd_idx;
    logic [kst_pkg::KEY_W-1:0]      r_key_rd;
    logic [kst_pkg::VAL_W-1:0]      r_val_rd;

    // result register
    logic                           r_out_valid;
    kst_pkg::t_status               r_status;
    logic [kst_pkg::VAL_W-1:0]      r_found;

    logic                           slot_match;
    logic                           slot_empty;
    kst_pkg::t_status               n_status;
    logic [kst_pkg::VAL_W-1:0]      n_found;

    assign slot_match = r_valid[r_idx] && (r_key_rd == r_key);
    assign slot_empty = !r_valid[r_idx];

    assign o_sts.skip     = (r_action == kst_pkg::ACT_CLEAR) || (r_key == '0);
    assign o_sts.last     = (r_idx == kst_pkg::LAST_IDX);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= kst_pkg::t_action'(i_action);
            r_key    <= i_serial;
            r_value  <= i_counter_value;
        end
    end

    // walk the slots, keep the first match and the lowest free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.step) begin
            if (!o_sts.last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (slot_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (slot_empty && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    // fetch the slot the scan examines next
    assign rd_idx = i_cmd.load ? '0 : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || (i_cmd.step && !o_sts.last)) begin
            r_key_rd <= r_key_mem[rd_idx];
            r_val_rd <= r_val_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && slot_match && !r_hit) begin
            r_hit_idx <= r_idx;
            r_hit_val <= r_val_rd;
        end
        if (i_cmd.step && slot_empty && !r_free) begin
            r_free_idx <= r_idx;
        end
    end

    // decide the outcome of the request
    always_comb begin
        n_status = kst_pkg::ST_OK;
        n_found  = '0;
        if (r_action == kst_pkg::ACT_CLEAR) begin
            n_status = kst_pkg::ST_OK;
        end else if (r_key == '0) begin
            n_status = kst_pkg::ST_INVALID;
        end else begin
            case (r_action)
                kst_pkg::ACT_ADD: begin
                    if (r_hit) begin
                        n_status = kst_pkg::ST_EXISTS;
                    end else if (!r_free) begin
                        n_status = kst_pkg::ST_FULL;
                    end
                end
                kst_pkg::ACT_REMOVE: begin
                    if (!r_hit) begin
                        n_status = kst_pkg::ST_NOT_FOUND;
                    end
                end
                kst_pkg::ACT_FIND: begin
                    if (!r_hit) begin
                        n_status = kst_pkg::ST_NOT_FOUND;
                    end else begin
                        n_found = r_hit_val;
                    end
                end
                default: begin
                    n_status = kst_pkg::ST_OK;
                end
            endcase
        end
    end

    // update valid bits and the occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (r_action == kst_pkg::ACT_CLEAR) begin
                r_valid <= '0;
                r_count <= '0;
            end else if (r_key != '0) begin
                if (r_action == kst_pkg::ACT_ADD && !r_hit && r_free) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_count             <= r_count + 1'b1;
                end else if (r_action == kst_pkg::ACT_REMOVE && r_hit) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_count            <= r_count - 1'b1;
                end
            end
        end
    end

    // write key and value into the claimed slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_action == kst_pkg::ACT_ADD && r_key != '0
                && !r_hit && r_free) begin
            r_key_mem[r_free_idx] <= r_key;
            r_val_mem[r_free_idx] <= r_value;
        end
    end

    // result register: load on commit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    // count in the result reflects the state after the request
    logic [kst_pkg::CNT_W-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_action == kst_pkg::ACT_CLEAR) begin
                r_out_count <= '0;
            end else if (r_key != '0 && r_action == kst_pkg::ACT_ADD
                    && !r_hit && r_free) begin
                r_out_count <= r_count + 1'b1;
            end else if (r_key != '0 && r_action == kst_pkg::ACT_REMOVE && r_hit) begin
                r_out_count <= r_count - 1'b1;
            end else begin
                r_out_count <= r_count;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_counter = r_found;
    assign o_entry_count   = r_out_count;

endmodule

// File: sv/keyed_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_slot_table: fixed associative table of keyed counter slots
// Add, remove, find or clear by 32-bit key; each request yields one result
// with a status, the found counter and the entry count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  in        request    i_in_valid / o_in_stall  i_action, i_serial, i_counter_value
//  out       result     o_out_valid / i_out_stall o_status, o_found_counter,
//                                                o_entry_count
//
//  A request is scanned one slot per cycle by the scan unit, then committed
//  once the result register has room.
//  Clear and key zero skip the slot scan.
//  Reset (synchronous, active low) empties the table at once.
//  A stalled result holds; the next request is accepted as soon as the
//  previous one has committed to the result register.
// ----------------------------------------------------------------------------
module keyed_slot_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [kst_pkg::KEY_W-1:0]    i_serial,
    input  logic [kst_pkg::VAL_W-1:0]    i_counter_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic [kst_pkg::VAL_W-1:0]    o_found_counter,
    output logic [kst_pkg::CNT_W-1:0]    o_entry_count
);

    kst_pkg::t_cmd cmd;
    kst_pkg::t_sts sts;

    kst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kst_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_serial        (i_serial),
        .i_counter_value (i_counter_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_found_counter (o_found_counter),
        .o_entry_count   (o_entry_count)
    );

endmodule

// File: bench/keyed_slot_table_test.sv
// ----------------------------------------------------------------------------
// keyed_slot_table_test: self-checking bench for the keyed slot table
// Feeds add, remove, find and clear requests from a queue, predicts every
// result with a behavioral copy of the table, and checks each result field.
// ----------------------------------------------------------------------------
module keyed_slot_table_test;

    localparam int KEY_POOL         = 24;
    localparam int RANDOM_REQUESTS  = 636;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int LONG_HOLD_AFTER  = 40;
    localparam int TAIL_REQUESTS    = 60;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        kst_pkg::t_action          act;
        logic [kst_pkg::KEY_W-1:0] key;
        logic [kst_pkg::VAL_W-1:0] value;
        logic                      drain;  // pause marker: wait for all results, send nothing
    } t_request;

    typedef struct packed {
        kst_pkg::t_status          status;
        logic [kst_pkg::VAL_W-1:0] found;
        logic [kst_pkg::CNT_W-1:0] count;
    } t_reply;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_in_valid      = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_action        = kst_pkg::ACT_CLEAR;
    logic [kst_pkg::KEY_W-1:0] i_serial        = '0;
    logic [kst_pkg::VAL_W-1:0] i_counter_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall     = 1'b0;
    logic [2:0]                o_status;
    logic [kst_pkg::VAL_W-1:0] o_found_counter;
    logic [kst_pkg::CNT_W-1:0] o_entry_count;

    keyed_slot_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_serial        (i_serial),
        .i_counter_value (i_counter_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_found_counter (o_found_counter),
        .o_entry_count   (o_entry_count)
    );

    // Run the clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------------
    logic                      slot_used  [kst_pkg::SLOT_COUNT];
    logic [kst_pkg::KEY_W-1:0] slot_key_m [kst_pkg::SLOT_COUNT];
    logic [kst_pkg::VAL_W-1:0] slot_val_m [kst_pkg::SLOT_COUNT];
    logic [kst_pkg::CNT_W-1:0] used_total;

    function automatic void wipe_table_model();
        int i;
        for (i = 0; i < kst_pkg::SLOT_COUNT; i++) begin
            slot_used[i]  = 1'b0;
            slot_key_m[i] = '0;
            slot_val_m[i] = '0;
        end
        used_total = '0;
    endfunction

    function automatic t_reply apply_request(t_request req);
        t_reply r;
        int     hit;
        int     free_slot;
        int     i;
        r.status  = kst_pkg::ST_OK;
        r.found   = '0;
        hit       = -1;
        free_slot = -1;
        if (req.act == kst_pkg::ACT_CLEAR) begin
            wipe_table_model();
        end else if (req.key == '0) begin
            r.status = kst_pkg::ST_INVALID;
        end else begin
            // locate the key and the lowest free slot in one pass
            for (i = 0; i < kst_pkg::SLOT_COUNT; i++) begin
                if (hit < 0 && slot_used[i] && slot_key_m[i] == req.key)
                    hit = i;
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            end
            case (req.act)
                kst_pkg::ACT_ADD: begin
                    if (hit >= 0) begin
                        r.status = kst_pkg::ST_EXISTS;
                    end else if (free_slot < 0) begin
                        r.status = kst_pkg::ST_FULL;
                    end else begin
                        slot_used[free_slot]  = 1'b1;
                        slot_key_m[free_slot] = req.key;
                        slot_val_m[free_slot] = req.value;
                        used_total            = used_total + 1'b1;
                    end
                end
                kst_pkg::ACT_REMOVE: begin
                    if (hit < 0) begin
                        r.status = kst_pkg::ST_NOT_FOUND;
                    end else begin
                        slot_used[hit]  = 1'b0;
                        slot_key_m[hit] = '0;
                        slot_val_m[hit] = '0;
                        used_total      = used_total - 1'b1;
                    end
                end
                default: begin
                    if (hit < 0)
                        r.status = kst_pkg::ST_NOT_FOUND;
                    else
                        r.found = slot_val_m[hit];
                end
            endcase
        end
        r.count = used_total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    t_request pending_requests [$];
    t_reply   expected_replies [$];
    t_request current_request;
    int       sender_gap        = 0;
    int       accepted_requests = 0;
    logic     quiet_tail        = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            wipe_table_model();
        end else begin
            // predict the transaction taken at this edge
            if (i_in_valid && !o_in_stall) begin
                expected_replies.push_back(apply_request(current_request));
                accepted_requests++;
            end
            // present the next request once the channel is free
            if (!i_in_valid || !o_in_stall) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_requests[0].drain) begin
                    if (expected_replies.size() == 0)
                        void'(pending_requests.pop_front());
                    i_in_valid <= 1'b0;
                end else begin
                    current_request = pending_requests.pop_front();
                    i_in_valid      <= 1'b1;
                    i_action        <= current_request.act;
                    i_serial        <= current_request.key;
                    i_counter_value <= current_request.value;
                    if (!quiet_tail && (accepted_requests / 80) % 4 != 3
                        && $urandom_range(0, 4) == 0)
                        sender_gap = $urandom_range(1, 4);
                end
            end
            quiet_tail <= (pending_requests.size() < TAIL_REQUESTS);
        end
    end

    // ------------------------------------------------------------------------
    // Result back-pressure: short random bursts plus one long hold
    // ------------------------------------------------------------------------
    int results_seen = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (!hold_done && results_seen >= LONG_HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet_tail && (results_seen / 80) % 4 != 1
                         && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    t_reply wanted_reply;
    int     mismatches = 0;
    int     status_seen [5] = '{default: 0};

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result status=%0d found=%h count=%0d",
                             o_status, o_found_counter, o_entry_count);
            end else begin
                wanted_reply = expected_replies.pop_front();
                status_seen[wanted_reply.status]++;
                if (o_status !== wanted_reply.status
                    || o_found_counter !== wanted_reply.found
                    || o_entry_count !== wanted_reply.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: result %0d expected status=%0d found=%h count=%0d,%s",
                                 results_seen, wanted_reply.status, wanted_reply.found,
                                 wanted_reply.count, " got");
                    if (mismatches <= MAX_REPORTS)
                        $display("       got status=%0d found=%h count=%0d",
                                 o_status, o_found_counter, o_entry_count);
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL keyed_slot_table");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_request(kst_pkg::t_action act, logic [kst_pkg::KEY_W-1:0] key,
                                 logic [kst_pkg::VAL_W-1:0] value);
        t_request req;
        req.act   = act;
        req.key   = key;
        req.value = value;
        req.drain = 1'b0;
        pending_requests.push_back(req);
    endtask

    task automatic queue_pause();
        t_request req;
        req       = '0;
        req.drain = 1'b1;
        pending_requests.push_back(req);
    endtask

    initial begin
        logic [kst_pkg::KEY_W-1:0] key_pool [KEY_POOL];
        logic [kst_pkg::KEY_W-1:0] k;
        kst_pkg::t_action          act;
        int                        pick;
        int                        i;

        // Build a small pool of nonzero keys so that hits and a full table are common
        for (i = 0; i < KEY_POOL; i++) begin
            k = $urandom();
            while (k == '0)
                k = $urandom();
            key_pool[i] = k;
        end

        // Directed: extremes, every action, every status but full
        queue_request(kst_pkg::ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(kst_pkg::ACT_FIND,   32'h0000_0001, 32'h0);
        queue_request(kst_pkg::ACT_ADD,    32'h0,         32'h0000_007B);
        queue_request(kst_pkg::ACT_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(kst_pkg::ACT_ADD,    32'hFFFF_FFFF, 32'h0);
        queue_request(kst_pkg::ACT_ADD,    32'h0000_0001, 32'h0);
        queue_request(kst_pkg::ACT_FIND,   32'hFFFF_FFFF, 32'h0);
        queue_request(kst_pkg::ACT_FIND,   32'h0,         32'hFFFF_FFFF);
        queue_request(kst_pkg::ACT_REMOVE, 32'h0,         32'h0);
        queue_request(kst_pkg::ACT_REMOVE, 32'h0000_0002, 32'h0);
        queue_request(kst_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        queue_request(kst_pkg::ACT_FIND,   32'hFFFF_FFFF, 32'h0);
        queue_request(kst_pkg::ACT_ADD,    32'h8000_0000, 32'h8000_0000);
        queue_request(kst_pkg::ACT_FIND,   32'h0000_0001, 32'h0);
        queue_request(kst_pkg::ACT_FIND,   32'h8000_0000, 32'h0);
        queue_request(kst_pkg::ACT_REMOVE, 32'h0000_0001, 32'h0);
        queue_request(kst_pkg::ACT_CLEAR,  32'h0,         32'h0);
        queue_pause();

        // Random: mostly pool keys, add-heavy so the table fills up
        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == RANDOM_REQUESTS / 2)
                queue_pause();
            k    = key_pool[$urandom_range(0, KEY_POOL - 1)];
            pick = $urandom_range(0, 199);
            if (pick < 6)
                k = '0;
            else if (pick < 16)
                k = $urandom();
            pick = $urandom_range(0, 199);
            if (pick < 90)
                act = kst_pkg::ACT_ADD;
            else if (pick < 135)
                act = kst_pkg::ACT_REMOVE;
            else if (pick < 197)
                act = kst_pkg::ACT_FIND;
            else
                act = kst_pkg::ACT_CLEAR;
            queue_request(act, k, $urandom());
        end

        // Hold reset, then release it for good
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come back
        while (pending_requests.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (kst_pkg::SLOT_COUNT + 8) @(posedge i_clk);

        $display("Covered %0d requests with random idling and one long result hold;",
                 accepted_requests);
        $display("statuses: ok %0d, bad key %0d, duplicate %0d, full %0d, missing %0d",
                 status_seen[kst_pkg::ST_OK], status_seen[kst_pkg::ST_INVALID],
                 status_seen[kst_pkg::ST_EXISTS], status_seen[kst_pkg::ST_FULL],
                 status_seen[kst_pkg::ST_NOT_FOUND]);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("PASS keyed_slot_table");
        end else begin
            $display("ERROR: %0d mismatching results", mismatches);
            $display("FAIL keyed_slot_table");
        end
        $finish;
    end

endmodule
